// ----- sv/gbn_pkg.sv -----
// Shared types and constants for the go-back-n sender window unit.
package gbn_pkg;

   localparam int SEQ_BITS      = 8;
   localparam int CNT_BITS      = 21;
   localparam int PAY_BITS      = 12;
   localparam int WIN_BITS      = 9;
   localparam int OFF_BITS      = 32;
   localparam int OP_BITS       = 2;
   localparam int KIND_BITS     = 2;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 21;

   localparam logic [PAY_BITS-1:0] PAY_RESET   = PAY_BITS'(32);
   localparam logic [WIN_BITS-1:0] WIN_RESET   = WIN_BITS'(256);
   localparam logic [CNT_BITS-1:0] TOTAL_RESET = CNT_BITS'(327680);

   typedef enum logic [OP_BITS-1:0] {
      OP_SEND    = 2'd0,
      OP_ACK     = 2'd1,
      OP_TIMEOUT = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_SENT  = 2'd0,
      KIND_WAIT  = 2'd1,
      KIND_ACKED = 2'd2,
      KIND_DONE  = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_PAYLOAD = 2'd0,
      CSR_WINDOW  = 2'd1,
      CSR_TOTAL   = 2'd2,
      CSR_SPARE   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [PAY_BITS-1:0] payload_bytes;
      logic [WIN_BITS-1:0] window_size;
      logic [CNT_BITS-1:0] packet_total;
   } cfg_type;

   typedef struct packed {
      logic [OP_BITS-1:0]  opcode;
      logic [SEQ_BITS-1:0] ack_value;
   } req_type;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [SEQ_BITS-1:0]  seq_number;
      logic [OFF_BITS-1:0]  byte_offset;
      logic [CNT_BITS-1:0]  sent_count_out;
      logic [SEQ_BITS-1:0]  rewind_amount;
   } rsp_type;

endpackage

// ----- sv/gbn_csr.sv -----
// Configuration registers of the go-back-n sender window unit.
module gbn_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [gbn_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [gbn_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output gbn_pkg::cfg_type                   cfg
);
   import gbn_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_PAYLOAD: cfg_in.payload_bytes = csr_data[PAY_BITS-1:0];
            CSR_WINDOW:  cfg_in.window_size   = csr_data[WIN_BITS-1:0];
            CSR_TOTAL:   cfg_in.packet_total  = csr_data[CNT_BITS-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.payload_bytes <= PAY_RESET;
         cfg_ff.window_size   <= WIN_RESET;
         cfg_ff.packet_total  <= TOTAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- sv/gbn_req_stage.sv -----
// Input register stage that holds one request ahead of the window core.
module gbn_req_stage (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [gbn_pkg::OP_BITS-1:0]       req_opcode,
   input  logic [gbn_pkg::SEQ_BITS-1:0]      req_ack_value,
   input  logic                              core_ready,
   output logic                              held_valid,
   output gbn_pkg::req_type                  held_req
);
   import gbn_pkg::*;

   logic    valid_ff;
   req_type req_ff;

   // Hold the request while the core cannot take it.
   assign req_stall  = valid_ff && !core_ready;
   assign held_valid = valid_ff;
   assign held_req   = req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff.opcode    <= req_opcode;
         req_ff.ack_value <= req_ack_value;
      end
   end

endmodule

// ----- sv/gbn_core.sv -----
// Window state, per-request update logic and the result register.
module gbn_core (
   input  logic               clock,
   input  logic               reset,
   input  gbn_pkg::cfg_type   cfg,
   input  logic               held_valid,
   input  gbn_pkg::req_type   held_req,
   output logic               core_ready,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output gbn_pkg::rsp_type   rsp
);
   import gbn_pkg::*;

   logic [CNT_BITS-1:0] sent_ff,   sent_in;
   logic [SEQ_BITS-1:0] seq_ff,    seq_in;
   logic [OFF_BITS-1:0] offset_ff, offset_in;
   logic [WIN_BITS-1:0] burst_ff,  burst_in;
   logic [SEQ_BITS-1:0] ack_ff,    ack_in;
   logic                out_valid_ff;
   rsp_type             rsp_ff, rsp_in;
   logic                has_result;
   logic                fire;

   logic [SEQ_BITS-1:0]          ack;
   logic [SEQ_BITS-1:0]          back;
   logic [SEQ_BITS-1:0]          removed;
   logic [CNT_BITS-1:0]          sent_rew;
   logic [CNT_BITS+PAY_BITS-1:0] prod;

   assign core_ready = !out_valid_ff || !rsp_stall;
   assign fire       = held_valid && core_ready;
   assign rsp_valid  = out_valid_ff;
   assign rsp        = rsp_ff;

   // Ack path: rewind distance, saturated at zero, then rebuild the offset.
   assign ack      = (opcode_type'(held_req.opcode) == OP_ACK) ? held_req.ack_value : ack_ff;
   assign back     = sent_ff[SEQ_BITS-1:0] - ack;
   assign removed  = (sent_ff >= CNT_BITS'(back)) ? back : sent_ff[SEQ_BITS-1:0];
   assign sent_rew = sent_ff - CNT_BITS'(removed);
   assign prod     = {{PAY_BITS{1'b0}}, sent_rew} * {{CNT_BITS{1'b0}}, cfg.payload_bytes};

   always_comb begin
      sent_in    = sent_ff;
      seq_in     = seq_ff;
      offset_in  = offset_ff;
      burst_in   = burst_ff;
      ack_in     = ack_ff;
      has_result = 1'b1;
      rsp_in     = '0;
      rsp_in.sent_count_out = sent_ff;
      case (opcode_type'(held_req.opcode)) inside
         OP_SEND: begin
            if (sent_ff >= cfg.packet_total) begin
               rsp_in.kind = (burst_ff == '0) ? KIND_DONE : KIND_WAIT;
            end else if (burst_ff >= cfg.window_size) begin
               rsp_in.kind = KIND_WAIT;
            end else begin
               sent_in   = sent_ff + CNT_BITS'(1);
               seq_in    = seq_ff + SEQ_BITS'(1);
               offset_in = offset_ff + OFF_BITS'(cfg.payload_bytes);
               burst_in  = burst_ff + WIN_BITS'(1);
               rsp_in.kind           = KIND_SENT;
               rsp_in.seq_number     = seq_ff;
               rsp_in.byte_offset    = offset_ff;
               rsp_in.sent_count_out = sent_in;
            end
         end
         OP_ACK, OP_TIMEOUT: begin
            ack_in   = ack;
            seq_in   = ack;
            burst_in = '0;
            rsp_in.kind = KIND_ACKED;
            if (ack != sent_ff[SEQ_BITS-1:0]) begin
               sent_in   = sent_rew;
               offset_in = prod[OFF_BITS-1:0];
               rsp_in.rewind_amount = removed;
            end
            rsp_in.seq_number     = ack;
            rsp_in.byte_offset    = offset_in;
            rsp_in.sent_count_out = sent_in;
         end
         default: begin
            has_result = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff      <= '0;
         seq_ff       <= '0;
         offset_ff    <= '0;
         burst_ff     <= '0;
         ack_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            sent_ff   <= sent_in;
            seq_ff    <= seq_in;
            offset_ff <= offset_in;
            burst_ff  <= burst_in;
            ack_ff    <= ack_in;
         end
         if (core_ready) begin
            out_valid_ff <= fire && has_result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && has_result) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ----- sv/go_back_n_sender_window_unit.sv -----
// Top level of the go-back-n sender window unit.
//
// Requests arrive on the req_ channel (valid/stall): opcode 0 asks for a
// send slot, 1 reports an ack carrying req_ack_value, 2 reports an ack
// timeout that repeats the last ack seen. Each request with opcode 0..2
// returns one result on the rsp_ channel: a packet descriptor (sequence
// number and payload byte offset), a wait, an ack summary with the rewind
// distance, or transfer done. Opcode 3 is consumed with no result.
// A request passes through the input register and then, once the core is
// ready, the result register. Throughput is one request per cycle while the
// receiver does not stall; the critical path is the ack rewind subtract
// feeding the 21x12 offset multiplier into the offset register.
// When the receiver stalls, the result register holds its value, the input
// register keeps one more request, and then req_stall rises.
// Reset clears the counters, sequence number, offset and the last ack and
// loads the default configuration; the unit takes requests the cycle after.
// The csr_ port writes payload_bytes (0), window_size (1), packet_total (2)
// and is always ready; write it only while the unit is idle.
module go_back_n_sender_window_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [gbn_pkg::OP_BITS-1:0]        req_opcode,
   input  logic [gbn_pkg::SEQ_BITS-1:0]       req_ack_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [gbn_pkg::KIND_BITS-1:0]      rsp_kind,
   output logic [gbn_pkg::SEQ_BITS-1:0]       rsp_seq_number,
   output logic [gbn_pkg::OFF_BITS-1:0]       rsp_byte_offset,
   output logic [gbn_pkg::CNT_BITS-1:0]       rsp_sent_count_out,
   output logic [gbn_pkg::SEQ_BITS-1:0]       rsp_rewind_amount,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [gbn_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [gbn_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import gbn_pkg::*;

   cfg_type cfg;
   req_type held_req;
   rsp_type rsp;
   logic    held_valid;
   logic    core_ready;

   // Configuration registers.
   gbn_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Input register: one request deep, drains whenever the core advances.
   gbn_req_stage u_req (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_ack_value (req_ack_value),
      .core_ready    (core_ready),
      .held_valid    (held_valid),
      .held_req      (held_req)
   );

   // Window state and result register.
   gbn_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .held_valid (held_valid),
      .held_req   (held_req),
      .core_ready (core_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp)
   );

   // Split the result request into its field ports.
   assign rsp_kind           = rsp.kind;
   assign rsp_seq_number     = rsp.seq_number;
   assign rsp_byte_offset    = rsp.byte_offset;
   assign rsp_sent_count_out = rsp.sent_count_out;
   assign rsp_rewind_amount  = rsp.rewind_amount;

`ifndef SYNTHESIS
   // Input side only backs up when a full result is blocked downstream.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a blocked result");

   // Only an ack summary may report a rewind.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind != KIND_ACKED)) |-> (rsp_rewind_amount == '0))
      else $error("rewind reported outside an ack result");

   // A sent packet always bumps the sent count above zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_SENT)) |-> (rsp_sent_count_out != '0))
      else $error("packet sent with zero sent count");

   // No result is presented right after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

// ----- sim/gbn_window_checker.sv -----
// Checker for the go-back-n sender window unit: predicts each result and compares it.
`timescale 1ns / 100ps

module gbn_window_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [gbn_pkg::OP_BITS-1:0]        req_opcode,
   input  logic [gbn_pkg::SEQ_BITS-1:0]       req_ack_value,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [gbn_pkg::KIND_BITS-1:0]      rsp_kind,
   input  logic [gbn_pkg::SEQ_BITS-1:0]       rsp_seq_number,
   input  logic [gbn_pkg::OFF_BITS-1:0]       rsp_byte_offset,
   input  logic [gbn_pkg::CNT_BITS-1:0]       rsp_sent_count_out,
   input  logic [gbn_pkg::SEQ_BITS-1:0]       rsp_rewind_amount,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [gbn_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [gbn_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output int                                 fail_count,
   output int                                 outstanding
);
   import gbn_pkg::*;

   // Shadow configuration and window state.
   logic [PAY_BITS-1:0] pay_cfg;
   logic [WIN_BITS-1:0] win_cfg;
   logic [CNT_BITS-1:0] total_cfg;
   logic [CNT_BITS-1:0] sent_cnt;
   logic [SEQ_BITS-1:0] seq_next;
   logic [SEQ_BITS-1:0] ack_last;
   logic [OFF_BITS-1:0] offset_acc;
   logic [WIN_BITS-1:0] burst_cnt;

   rsp_type pending_q[$];

   task automatic flag_error(input string msg);
      $display("%0t ERROR: %s", $time, msg);
      fail_count++;
   endtask

   // Advance the window by one request; return 1 when it yields a result.
   function automatic bit advance_window(input opcode_type op,
                                         input logic [SEQ_BITS-1:0] ack_in,
                                         output rsp_type res);
      logic [SEQ_BITS-1:0] ack;
      logic [SEQ_BITS-1:0] back;
      logic [SEQ_BITS-1:0] removed;
      res = '0;
      case (op) inside
         OP_SEND: begin
            res.sent_count_out = sent_cnt;
            if (sent_cnt >= total_cfg) begin
               res.kind = (burst_cnt == '0) ? KIND_DONE : KIND_WAIT;
            end else if (burst_cnt >= win_cfg) begin
               res.kind = KIND_WAIT;
            end else begin
               res.kind        = KIND_SENT;
               res.seq_number  = seq_next;
               res.byte_offset = offset_acc;
               seq_next        = seq_next + 1'b1;
               offset_acc      = offset_acc + {20'b0, pay_cfg};
               sent_cnt        = sent_cnt + 1'b1;
               burst_cnt       = burst_cnt + 1'b1;
               res.sent_count_out = sent_cnt;
            end
            return 1'b1;
         end
         OP_ACK, OP_TIMEOUT: begin
            ack      = (op == OP_ACK) ? ack_in : ack_last;
            ack_last = ack;
            removed  = '0;
            if (ack != sent_cnt[SEQ_BITS-1:0]) begin
               back       = sent_cnt[SEQ_BITS-1:0] - ack;
               removed    = (sent_cnt >= back) ? back : sent_cnt[SEQ_BITS-1:0];
               sent_cnt   = sent_cnt - removed;
               offset_acc = {11'b0, sent_cnt} * {20'b0, pay_cfg};
            end
            seq_next  = ack;
            burst_cnt = '0;
            res.kind           = KIND_ACKED;
            res.seq_number     = seq_next;
            res.byte_offset    = offset_acc;
            res.sent_count_out = sent_cnt;
            res.rewind_amount  = removed;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         pay_cfg    = PAY_RESET;
         win_cfg    = WIN_RESET;
         total_cfg  = TOTAL_RESET;
         sent_cnt   = '0;
         seq_next   = '0;
         ack_last   = '0;
         offset_acc = '0;
         burst_cnt  = '0;
         pending_q.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PAYLOAD: pay_cfg   = csr_data[PAY_BITS-1:0];
               CSR_WINDOW:  win_cfg   = csr_data[WIN_BITS-1:0];
               CSR_TOTAL:   total_cfg = csr_data[CNT_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_q.size() == 0) begin
               flag_error("result with no request waiting for it");
            end else begin
               want = pending_q.pop_front();
               if (rsp_kind !== want.kind)
                  flag_error($sformatf("kind got %0d want %0d", rsp_kind, want.kind));
               if (rsp_seq_number !== want.seq_number)
                  flag_error($sformatf("seq_number got %0d want %0d",
                                       rsp_seq_number, want.seq_number));
               if (rsp_byte_offset !== want.byte_offset)
                  flag_error($sformatf("byte_offset got %0d want %0d",
                                       rsp_byte_offset, want.byte_offset));
               if (rsp_sent_count_out !== want.sent_count_out)
                  flag_error($sformatf("sent_count_out got %0d want %0d",
                                       rsp_sent_count_out, want.sent_count_out));
               if (rsp_rewind_amount !== want.rewind_amount)
                  flag_error($sformatf("rewind_amount got %0d want %0d",
                                       rsp_rewind_amount, want.rewind_amount));
            end
         end
         if (req_valid && !req_stall) begin
            if (advance_window(opcode_type'(req_opcode), req_ack_value, want))
               pending_q.push_back(want);
         end
      end
      outstanding = pending_q.size();
   end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the go-back-n sender window unit: stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb_top;
   import gbn_pkg::*;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [OP_BITS-1:0]        req_opcode;
   logic [SEQ_BITS-1:0]       req_ack_value;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [KIND_BITS-1:0]      rsp_kind;
   logic [SEQ_BITS-1:0]       rsp_seq_number;
   logic [OFF_BITS-1:0]       rsp_byte_offset;
   logic [CNT_BITS-1:0]       rsp_sent_count_out;
   logic [SEQ_BITS-1:0]       rsp_rewind_amount;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_IDX_BITS-1:0]   csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;
   int                        fail_count;
   int                        outstanding;

   // Loose guess of where the window stands, used only to shape acks that
   // land inside the burst just sent. The checker holds the exact state.
   logic [SEQ_BITS-1:0] guess_seq;
   logic [SEQ_BITS-1:0] guess_last_ack;
   int                  guess_burst;
   int                  cur_win;

   // Sender burst bookkeeping and long receiver hold-off requests.
   int burst_left;
   int holds_asked;

   go_back_n_sender_window_unit DUT (.*);

   gbn_window_checker window_watch (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #5_000_000;
      $display("%0t ERROR: run timed out", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Offer one request at the next falling edge and hold it until accepted.
   // Between bursts, drop valid for a random gap. Returns just after the
   // accepting rising edge.
   task automatic drive_request(input opcode_type op, input logic [SEQ_BITS-1:0] ack);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid     = 1'b1;
      req_opcode    = op;
      req_ack_value = ack;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // Track the guess of the next sequence number.
      case (op)
         OP_SEND: begin
            if (guess_burst < cur_win) begin
               guess_seq++;
               guess_burst++;
            end
         end
         OP_ACK: begin
            guess_seq      = ack;
            guess_last_ack = ack;
            guess_burst    = 0;
         end
         OP_TIMEOUT: begin
            guess_seq   = guess_last_ack;
            guess_burst = 0;
         end
         default: ;
      endcase
   endtask

   // Write one register; leave csr_valid high so writes can run back to back.
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Drain the unit, then load a full configuration plus a write to the
   // unused index, which the unit must ignore.
   task automatic configure(input logic [PAY_BITS-1:0] pay, input logic [WIN_BITS-1:0] win,
                            input logic [CNT_BITS-1:0] total);
      @(negedge clock);
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      // An opcode 3 request may still sit in the pipe with no result owed.
      repeat (3) @(negedge clock);
      write_reg(CSR_PAYLOAD, CSR_DATA_BITS'(pay));
      write_reg(CSR_WINDOW, CSR_DATA_BITS'(win));
      write_reg(CSR_TOTAL, total);
      write_reg(CSR_SPARE, CSR_DATA_BITS'($urandom));
      @(negedge clock);
      csr_valid = 1'b0;
      @(posedge clock);
      cur_win    = win;
      burst_left = 0;
   endtask

   // Mostly well-formed bursts: a run of send slots closed by an ack that
   // falls inside the burst. Mix in timeouts, stray acks and plain noise.
   // Opcode 3 requests do not count toward the total.
   task automatic run_traffic(input int count);
      int                  done_items;
      int                  len;
      int                  pick;
      opcode_type          op;
      done_items = 0;
      while (done_items < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            len = $urandom_range(0, (cur_win < 30) ? cur_win + 2 : 32);
            repeat (len) drive_request(OP_SEND, SEQ_BITS'($urandom));
            done_items += len;
            pick = $urandom_range(0, 99);
            if (pick < 75)
               drive_request(OP_ACK, guess_seq -
                             SEQ_BITS'($urandom_range(0, (guess_burst < 255) ? guess_burst : 255)));
            else if (pick < 90)
               drive_request(OP_TIMEOUT, SEQ_BITS'($urandom));
            else
               drive_request(OP_ACK, SEQ_BITS'($urandom));
            done_items++;
         end else begin
            op = opcode_type'($urandom_range(0, 3));
            drive_request(op, SEQ_BITS'($urandom));
            if (op != OP_NONE) done_items++;
         end
      end
   endtask

   // Receiver: stall on a pattern of its own, segment by segment. When the
   // sender asks, hold off for a long stretch so the unit backs up.
   initial begin : receiver
      int seg_len;
      int mode;
      int holds_done;
      int hold_left;
      holds_done = 0;
      hold_left  = 0;
      rsp_stall  = 1'b0;
      forever begin
         seg_len = $urandom_range(8, 60);
         mode    = $urandom_range(0, 3);
         repeat (seg_len) begin
            @(negedge clock);
            if (hold_left == 0 && holds_asked > holds_done) begin
               holds_done++;
               hold_left = 64;
            end
            if (hold_left > 0) begin
               rsp_stall = 1'b1;
               hold_left--;
            end else begin
               case (mode)
                  0: rsp_stall = 1'b0;
                  1: rsp_stall = ($urandom_range(0, 3) == 0);
                  2: rsp_stall = ($urandom_range(0, 3) != 0);
                  default: rsp_stall = ~rsp_stall;
               endcase
            end
         end
      end
   end

   initial begin : stimulus
      int                  phase;
      int                  wait_left;
      logic [PAY_BITS-1:0] pay;
      logic [WIN_BITS-1:0] win;
      logic [CNT_BITS-1:0] total;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_opcode     = OP_SEND;
      req_ack_value  = '0;
      csr_valid      = 1'b0;
      csr_index      = CSR_PAYLOAD;
      csr_data       = '0;
      guess_seq      = '0;
      guess_last_ack = '0;
      guess_burst    = 0;
      cur_win        = WIN_RESET;
      burst_left     = 0;
      holds_asked    = 0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      // Default configuration: three packets, then acks that match, rewind,
      // repeat on timeout, saturate at zero, and one unused opcode.
      drive_request(OP_SEND, 8'h00);
      drive_request(OP_SEND, 8'h00);
      drive_request(OP_SEND, 8'hFF);
      drive_request(OP_ACK, 8'd3);
      drive_request(OP_ACK, 8'd1);
      drive_request(OP_TIMEOUT, 8'h00);
      drive_request(OP_NONE, 8'hAA);
      drive_request(OP_ACK, 8'hFF);
      drive_request(OP_ACK, 8'h55);
      drive_request(OP_SEND, 8'h00);

      // Zero payload; total reached inside an open burst, then transfer done.
      configure('0, 9'd4, 21'd3);
      drive_request(OP_SEND, 8'h00);
      drive_request(OP_SEND, 8'h00);
      drive_request(OP_SEND, 8'h00);
      drive_request(OP_ACK, 8'd3);
      drive_request(OP_SEND, 8'h00);
      drive_request(OP_TIMEOUT, 8'h00);

      // Largest payload, window of one, all-ones total: window limit hit.
      configure(12'hFFF, 9'd1, 21'h1FFFFF);
      drive_request(OP_SEND, 8'h00);
      drive_request(OP_SEND, 8'h00);
      drive_request(OP_TIMEOUT, 8'h00);

      // Window of zero: nothing goes out; a rewind to zero in between.
      configure(12'd2048, '0, 21'd1048576);
      drive_request(OP_SEND, 8'h00);
      drive_request(OP_ACK, 8'h00);
      drive_request(OP_SEND, 8'h00);

      // Wide window with the long receiver hold-off so the unit fills up.
      configure(12'd1, 9'd511, 21'd1048576);
      holds_asked++;
      run_traffic(32);

      // Tiny total: mostly wait and done answers, with rewinds in between.
      configure(12'd2048, 9'd1, 21'd1);
      run_traffic(32);

      for (phase = 0; phase < 8; phase++) begin
         case ($urandom_range(0, 4))
            0: pay = '0;
            1: pay = 12'd1;
            2: pay = 12'd2048;
            3: pay = 12'hFFF;
            default: pay = PAY_BITS'($urandom_range(1, 2048));
         endcase
         case ($urandom_range(0, 5))
            0: win = '0;
            1: win = 9'd1;
            2: win = 9'd256;
            3: win = 9'd511;
            4: win = WIN_BITS'($urandom_range(2, 16));
            default: win = WIN_BITS'($urandom_range(1, 8));
         endcase
         case ($urandom_range(0, 5))
            0: total = '0;
            1: total = 21'd1;
            2: total = 21'h1FFFFF;
            3: total = 21'd1048576;
            default: total = CNT_BITS'($urandom_range(1, 600));
         endcase
         configure(pay, win, total);
         run_traffic(32);
      end

      // Drain, then allow the pipeline latency before the verdict.
      @(negedge clock);
      req_valid = 1'b0;
      wait_left = 5000;
      while (outstanding != 0 && wait_left > 0) begin
         @(negedge clock);
         wait_left--;
      end
      repeat (5) @(negedge clock);
      if (outstanding != 0)
         $display("%0t ERROR: %0d predicted results never arrived", $time, outstanding);
      if (fail_count == 0 && outstanding == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
